[sv/fmhd_pkg.sv]
// Shared types, codes and constants for the FM Hilbert phase demodulator.
package fmhd_pkg;

    localparam int PHASE_W = 16;
    localparam int FREQ_W  = 26;
    localparam int FS_W    = 20;
    localparam int ANGLE_W = 32;

    localparam logic [FS_W-1:0] FS_RESET = FS_W'(8000);
    localparam logic [FS_W-1:0] FC_RESET = FS_W'(1000);

    // register indexes on the APB port
    localparam logic REG_SAMPLE_RATE = 1'b0;
    localparam logic REG_CARRIER     = 1'b1;

    // what a window position does to the result stream
    localparam logic [1:0] EV_PRIME = 2'd0;   // first of stream: phase seed; 0 at eos
    localparam logic [1:0] EV_ONE   = 2'd1;
    localparam logic [1:0] EV_TWO   = 2'd2;   // second of stream: result given twice

    typedef struct packed {
        logic       valid;
        logic [1:0] ev;
        logic       eos;
        logic       zero;
    } ctl_t;

    // atan(2^-i) in 2^-32 turns
    function automatic logic [ANGLE_W-1:0] cordic_angle(input int idx);
        logic [ANGLE_W-1:0] a;
        a = '0;
        case (idx)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[sv/fmhd_hilbert.sv]
// Sample window cells, Hilbert tap products and registered adder tree.
module fmhd_hilbert #(
    parameter int HALF_TAPS    = 20,
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACCW         = 52
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            shift,
    input  logic                            clear,
    input  logic signed [SAMPLE_WIDTH-1:0]  din,
    input  fmhd_pkg::ctl_t                  ctl_in,
    output fmhd_pkg::ctl_t                  ctl_out,
    output logic signed [SAMPLE_WIDTH-1:0]  center_out,
    output logic signed [ACCW-1:0]          sum_out
);
    import fmhd_pkg::*;

    localparam int WIN = 2 * HALF_TAPS + 1;
    localparam int NL  = (HALF_TAPS + 1) / 2;
    localparam int LV  = $clog2(NL);
    localparam int NP  = 2 ** LV;

    logic signed [SAMPLE_WIDTH-1:0] win_reg [WIN];
    ctl_t                           ctl0_reg;
    logic signed [ACCW-1:0]         lvl_reg [LV+1][NP];
    ctl_t                           ctl_reg [LV+1];
    logic signed [SAMPLE_WIDTH-1:0] cen_reg [LV+1];
    logic signed [ACCW-1:0]         prod_next [NP];

    // window: each cell takes its newer neighbour, or zero on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                win_reg[i] <= '0;
            end
            ctl0_reg <= '0;
        end
        else if (adv)
        begin
            ctl0_reg <= ctl_in;
            if (shift)
            begin
                for (int i = 0; i < WIN - 1; i++)
                begin
                    win_reg[i] <= clear ? '0 : win_reg[i+1];
                end
                win_reg[WIN-1] <= din;
            end
        end
    end

    genvar j;
    generate
        for (j = 0; j < NP; j++)
        begin : g_lane
            if (j < NL)
            begin : g_tap
                localparam longint K    = 2 * j + 1;
                localparam longint TAPV = (64'sd683565276 + K / 2) / K;
                localparam logic signed [ACCW-1:0] TAPC = ACCW'(TAPV);
                logic signed [SAMPLE_WIDTH:0] diff;
                logic signed [ACCW-1:0]       de;
                assign diff = (SAMPLE_WIDTH+1)'(win_reg[HALF_TAPS + 2*j + 1])
                            - (SAMPLE_WIDTH+1)'(win_reg[HALF_TAPS - 2*j - 1]);
                assign de = ACCW'(diff);
                assign prod_next[j] = de * TAPC;
            end
            else
            begin : g_pad
                assign prod_next[j] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l <= LV; l++)
            begin
                ctl_reg[l] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_reg[0] <= ctl0_reg;
            for (int l = 0; l < LV; l++)
            begin
                ctl_reg[l+1] <= ctl_reg[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lvl_reg[0] <= prod_next;
            cen_reg[0] <= win_reg[HALF_TAPS];
            for (int l = 0; l < LV; l++)
            begin
                cen_reg[l+1] <= cen_reg[l];
                for (int i = 0; i < NP; i++)
                begin
                    if (i < (NP >> (l + 1)))
                    begin
                        lvl_reg[l+1][i] <= lvl_reg[l][2*i] + lvl_reg[l][2*i+1];
                    end
                    else
                    begin
                        lvl_reg[l+1][i] <= '0;
                    end
                end
            end
        end
    end

    assign ctl_out    = ctl_reg[LV];
    assign center_out = cen_reg[LV];
    assign sum_out    = lvl_reg[LV][0];

endmodule

[sv/fmhd_cordic_cell.sv]
// One vectoring CORDIC step, registered.
module fmhd_cordic_cell #(
    parameter int CW  = 40,
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic signed [CW-1:0]  x_in,
    input  logic signed [CW-1:0]  y_in,
    input  logic [31:0]           z_in,
    input  fmhd_pkg::ctl_t        ctl_in,
    output logic signed [CW-1:0]  x_out,
    output logic signed [CW-1:0]  y_out,
    output logic [31:0]           z_out,
    output fmhd_pkg::ctl_t        ctl_out
);
    import fmhd_pkg::*;

    localparam logic [ANGLE_W-1:0] ANG = cordic_angle(IDX);

    logic signed [CW-1:0] xs, ys, x_next, y_next;
    logic [ANGLE_W-1:0]   z_next;
    ctl_t                 ctl_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic [ANGLE_W-1:0]   z_reg;

    assign xs = x_in >>> IDX;
    assign ys = y_in >>> IDX;

    always_comb
    begin
        if (!y_in[CW-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ANG;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign ctl_out = ctl_reg;

endmodule

[sv/fmhd_freq.sv]
// Phase rounding, wrapped difference, scaling by fs and carrier removal.
module fmhd_freq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic [31:0]                       z_in,
    input  fmhd_pkg::ctl_t                    ctl_in,
    input  logic [fmhd_pkg::FS_W-1:0]         fs,
    input  logic [fmhd_pkg::FS_W-1:0]         fc,
    output logic                              res_valid,
    output logic                              res_dup,
    output logic                              res_eos,
    output logic signed [fmhd_pkg::FREQ_W-1:0] res_freq
);
    import fmhd_pkg::*;

    localparam int PW = PHASE_W + FS_W + 1;
    localparam int RW = PW + 1;
    localparam logic signed [RW-1:0] FMAX = RW'((64'sd1 <<< (FREQ_W - 1)) - 1);
    localparam logic signed [RW-1:0] FMIN = -RW'(64'sd1 <<< (FREQ_W - 1));

    logic [31:0]               zr;
    logic [PHASE_W-1:0]        phase;
    logic [PHASE_W-1:0]        prev_reg;
    logic signed [PHASE_W-1:0] d_reg;
    ctl_t                      ca_reg, cb_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [PW-1:0]      ps, q;
    logic signed [RW-1:0]      r;
    logic signed [FREQ_W-1:0]  sat;
    logic                      val_reg, dup_reg, eos_reg;
    logic signed [FREQ_W-1:0]  freq_reg;

    assign zr    = z_in + 32'h0000_8000;
    assign phase = ctl_in.zero ? '0 : zr[31:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            ca_reg   <= '0;
            cb_reg   <= '0;
            val_reg  <= 1'b0;
            dup_reg  <= 1'b0;
            eos_reg  <= 1'b0;
        end
        else if (adv)
        begin
            if (ctl_in.valid)
            begin
                prev_reg <= phase;
            end
            ca_reg  <= ctl_in;
            cb_reg  <= ca_reg;
            val_reg <= cb_reg.valid && ((cb_reg.ev != EV_PRIME) || cb_reg.eos);
            dup_reg <= cb_reg.ev == EV_TWO;
            eos_reg <= cb_reg.eos;
        end
    end

    assign ps = prod_reg + PW'(2048);
    assign q  = ps >>> 12;
    assign r  = RW'(q) - RW'({fc, 4'b0000});

    always_comb
    begin
        if (r > FMAX)
        begin
            sat = FREQ_W'(FMAX);
        end
        else if (r < FMIN)
        begin
            sat = FREQ_W'(FMIN);
        end
        else
        begin
            sat = FREQ_W'(r);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg    <= signed'(phase - prev_reg);
            prod_reg <= PW'(d_reg) * signed'(PW'({1'b0, fs}));
            freq_reg <= (cb_reg.ev == EV_PRIME) ? '0 : sat;
        end
    end

    assign res_valid = val_reg;
    assign res_dup   = dup_reg;
    assign res_eos   = eos_reg;
    assign res_freq  = freq_reg;

endmodule

[sv/fm_hilbert_phase_demodulator_unit.sv]
// Top level of the FM Hilbert phase demodulator.
//
// Takes one Q1.15 sample per clock while in_ready is high and gives the
// instantaneous frequency minus the carrier in 1/16 Hz. The samples shift
// through a row of window cells; the odd Hilbert taps are multiplied in one
// stage of lanes and summed by a registered adder tree, a chain of
// CORDIC_STEPS cells turns (sample, hilbert) into a phase in turns, and a
// three-stage back end takes the wrapped phase step, scales it by
// sample_rate_hz and removes carrier_hz. Results trail their input by
// HALF_TAPS samples; the transaction marked 'last' is followed by a flush
// of HALF_TAPS zero samples into the window, during which in_ready is low.
// The second result of a stream is shown twice (it stands in for the
// first), which holds the pipeline until the first copy is taken. The
// whole pipeline advances together; it stalls while the output register
// holds a result that is not taken or the first copy of a doubled result.
// A one-sample stream gives a single zero result. Registers sit on an APB
// port: sample_rate_hz at 0x0, carrier_hz at 0x4; write them only while
// the block is idle.
module fm_hilbert_phase_demodulator_unit #(
    parameter int HALF_TAPS    = 20,
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample,
    input  logic                               last,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [fmhd_pkg::FREQ_W-1:0] freq_offset,
    output logic                               end_of_stream,
    // APB
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import fmhd_pkg::*;

    localparam int NL   = (HALF_TAPS + 1) / 2;
    localparam int ACCW = SAMPLE_WIDTH + 33 + $clog2(NL);
    localparam int CW   = ACCW - 12;
    localparam int CNTW = $clog2(HALF_TAPS + 3);
    localparam int TW   = $clog2(HALF_TAPS + 1);

    // ---------------- configuration registers ----------------
    logic [FS_W-1:0] fs_reg, fc_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= FS_RESET;
            fc_reg <= FC_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_SAMPLE_RATE: fs_reg <= pwdata[FS_W-1:0];
                REG_CARRIER:     fc_reg <= pwdata[FS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SAMPLE_RATE: prdata = {{(32-FS_W){1'b0}}, fs_reg};
            REG_CARRIER:     prdata = {{(32-FS_W){1'b0}}, fc_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------- stream control ----------------
    // warm_reg counts window positions of the stream, saturating; it sets
    // which of prime / doubled / single result a position produces.
    logic            adv;
    logic            step;
    logic            final_step;
    logic [CNTW-1:0] warm_reg;
    logic [TW-1:0]   t_reg;
    logic            flush_reg;
    logic            clear_reg;
    ctl_t            ctl_step;
    logic            out_valid_reg, out_dup_reg, out_eos_reg;
    logic signed [FREQ_W-1:0] out_freq_reg;

    // pipeline moves when the output register is free or emptying for good
    assign adv        = !out_valid_reg || (out_ready && !out_dup_reg);
    assign in_ready   = adv && !flush_reg;
    assign step       = (in_valid && in_ready) || (flush_reg && adv);
    assign final_step = flush_reg && (t_reg == TW'(HALF_TAPS));

    always_comb
    begin
        ctl_step.valid = step && (warm_reg >= CNTW'(HALF_TAPS));
        ctl_step.eos   = final_step;
        ctl_step.zero  = 1'b0;
        if (warm_reg == CNTW'(HALF_TAPS))
        begin
            ctl_step.ev = EV_PRIME;
        end
        else if (warm_reg == CNTW'(HALF_TAPS + 1))
        begin
            ctl_step.ev = EV_TWO;
        end
        else
        begin
            ctl_step.ev = EV_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg  <= '0;
            t_reg     <= '0;
            flush_reg <= 1'b0;
            clear_reg <= 1'b0;
        end
        else if (step)
        begin
            clear_reg <= final_step;
            if (final_step)
            begin
                warm_reg <= '0;
            end
            else if (warm_reg < CNTW'(HALF_TAPS + 2))
            begin
                warm_reg <= warm_reg + 1'b1;
            end
            if (flush_reg)
            begin
                if (final_step)
                begin
                    flush_reg <= 1'b0;
                end
                t_reg <= t_reg + 1'b1;
            end
            else if (last)
            begin
                flush_reg <= 1'b1;
                t_reg     <= TW'(1);
            end
        end
    end

    // ---------------- Hilbert filter ----------------
    ctl_t                           ctl_h;
    logic signed [SAMPLE_WIDTH-1:0] cen_h;
    logic signed [ACCW-1:0]         sum_h;
    logic signed [SAMPLE_WIDTH-1:0] din;

    assign din = flush_reg ? '0 : sample;

    fmhd_hilbert #(
        .HALF_TAPS    (HALF_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACCW         (ACCW)
    ) u_hilbert (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .shift      (step),
        .clear      (clear_reg),
        .din        (din),
        .ctl_in     (ctl_step),
        .ctl_out    (ctl_h),
        .center_out (cen_h),
        .sum_out    (sum_h)
    );

    // ---------------- CORDIC front: fold into right half-plane ----------------
    logic signed [CW-1:0]   xe, ye;
    logic signed [ACCW-1:0] ysh;
    logic signed [CW-1:0]   cx [CORDIC_STEPS+1];
    logic signed [CW-1:0]   cy [CORDIC_STEPS+1];
    logic [31:0]            cz [CORDIC_STEPS+1];
    ctl_t                   cc [CORDIC_STEPS+1];
    ctl_t                   ctl_p;

    assign xe  = CW'(cen_h) <<< 16;
    assign ysh = sum_h >>> 14;
    assign ye  = ysh[CW-1:0];

    always_comb
    begin
        ctl_p      = ctl_h;
        ctl_p.zero = (cen_h == '0) && (ye == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc[0] <= '0;
        end
        else if (adv)
        begin
            cc[0] <= ctl_p;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx[0] <= xe[CW-1] ? -xe : xe;
            cy[0] <= xe[CW-1] ? -ye : ye;
            cz[0] <= xe[CW-1] ? 32'h8000_0000 : 32'h0000_0000;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++)
        begin : g_cordic
            fmhd_cordic_cell #(
                .CW  (CW),
                .IDX (gi)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .x_in    (cx[gi]),
                .y_in    (cy[gi]),
                .z_in    (cz[gi]),
                .ctl_in  (cc[gi]),
                .x_out   (cx[gi+1]),
                .y_out   (cy[gi+1]),
                .z_out   (cz[gi+1]),
                .ctl_out (cc[gi+1])
            );
        end
    endgenerate

    // ---------------- frequency back end ----------------
    logic                     res_valid, res_dup, res_eos;
    logic signed [FREQ_W-1:0] res_freq;

    fmhd_freq u_freq (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .z_in      (cz[CORDIC_STEPS]),
        .ctl_in    (cc[CORDIC_STEPS]),
        .fs        (fs_reg),
        .fc        (fc_reg),
        .res_valid (res_valid),
        .res_dup   (res_dup),
        .res_eos   (res_eos),
        .res_freq  (res_freq)
    );

    // ---------------- output register ----------------
    // a doubled result stays for a second transaction; end_of_stream only
    // on the copy that is shown last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_dup_reg   <= 1'b0;
            out_eos_reg   <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res_valid;
            out_dup_reg   <= res_valid && res_dup;
            out_eos_reg   <= res_eos;
        end
        else if (out_ready && out_dup_reg)
        begin
            out_dup_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_freq_reg <= res_freq;
        end
    end

    assign out_valid     = out_valid_reg;
    assign freq_offset   = out_freq_reg;
    assign end_of_stream = out_eos_reg && !out_dup_reg;

endmodule

[sv/fmhd_checker.sv]
// Port-level assertions for the FM Hilbert phase demodulator, with bind.
module fmhd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [25:0] freq_offset,
    input logic        end_of_stream
);

    // a result held back keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(freq_offset)
                                    && $stable(end_of_stream))
        else $error("result changed while stalled");

    // the tail flush keeps the input closed after the last sample
    a_flush_closed: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input open during tail flush");

    // input only opens when the output side is moving or empty
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> out_ready)
        else $error("input ready while output stalled");

endmodule

bind fm_hilbert_phase_demodulator_unit fmhd_checker u_fmhd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .freq_offset   (freq_offset),
    .end_of_stream (end_of_stream)
);
